FILE: rtl/core/tlb_page_table_translator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page table translator
// Concurrent checks that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH

`ifndef SYNTHESIS
`define TLBPT_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define TLBPT_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TLBPT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TLBPT_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define TLBPT_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define TLBPT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/core/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// Page table translator package
// Widths, limits, TLB command codes and shared types.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

   localparam int TLB_DEPTH_DEF = 16;
   localparam int PAGE_COUNT    = 256;
   localparam int FRAME_COUNT   = 256;

   localparam int ADDR_W      = 16;
   localparam int PAGE_W      = 8;
   localparam int OFFSET_W    = 8;
   localparam int FRAME_W     = 8;
   localparam int NEXT_FRAME_W = 9;
   localparam int TOTAL_W     = 16;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hFFFF;

   localparam logic [1:0] TLB_HOLD   = 2'd0;
   localparam logic [1:0] TLB_ROTATE = 2'd1;
   localparam logic [1:0] TLB_DROP   = 2'd2;
   localparam logic [1:0] TLB_APPEND = 2'd3;

   typedef struct packed {
      logic [PAGE_W-1:0]  tag;
      logic [FRAME_W-1:0] frame;
   } tlb_entry_type;

   typedef struct packed {
      logic [1:0]    op;
      tlb_entry_type entry;
   } tlb_cmd_type;

endpackage

FILE: rtl/core/tlbpt_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tlbpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/tlbpt_tlb.sv
// ----------------------------------------------------------------------------
// Recency-ordered TLB shift line
// Slot 0 is the oldest entry; each command but hold pops the head, reinserts it or appends.
// ----------------------------------------------------------------------------
`include "tlb_page_table_translator_macros.svh"

module tlbpt_tlb import tlbpt_pkg::*; #(
   parameter int DEPTH = TLB_DEPTH_DEF,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  tlb_cmd_type       cmd,
   output tlb_entry_type     head,
   output logic [CNT_W-1:0]  count
);

   tlb_entry_type    slot_ff [DEPTH];
   tlb_entry_type    slot_in [DEPTH];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             full;
   logic             shift;
   logic             ins_en;
   logic [CNT_W-1:0] ins_pos;
   tlb_entry_type    ins_data;

   assign full = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      shift    = 1'b0;
      ins_en   = 1'b0;
      ins_pos  = count_ff;
      ins_data = cmd.entry;
      count_in = count_ff;
      case (cmd.op)
         TLB_ROTATE: begin
            shift    = 1'b1;
            ins_en   = 1'b1;
            ins_pos  = count_ff - CNT_W'(1);
            ins_data = slot_ff[0];
         end
         TLB_DROP: begin
            shift    = 1'b1;
            count_in = count_ff - CNT_W'(1);
         end
         TLB_APPEND: begin
            ins_en = 1'b1;
            if (full) begin
               shift   = 1'b1;
               ins_pos = CNT_W'(DEPTH - 1);
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         default: begin
            shift = 1'b0;
         end
      endcase
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_slot
      if (i < DEPTH - 1) begin : g_mid
         always_comb begin
            if (ins_en && ins_pos == CNT_W'(i)) begin
               slot_in[i] = ins_data;
            end else if (shift) begin
               slot_in[i] = slot_ff[i+1];
            end else begin
               slot_in[i] = slot_ff[i];
            end
         end
      end else begin : g_last
         always_comb begin
            if (ins_en && ins_pos == CNT_W'(i)) begin
               slot_in[i] = ins_data;
            end else begin
               slot_in[i] = slot_ff[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head  = slot_ff[0];
   assign count = count_ff;

   `TLBPT_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "TLB count above depth")
   `TLBPT_ASSERT_IMPLY(a_pop_nonempty, clock, reset, cmd.op == TLB_ROTATE || cmd.op == TLB_DROP, count_ff != '0, "TLB head popped while empty")

endmodule

FILE: rtl/core/tlb_page_table_translator.sv
// ----------------------------------------------------------------------------
// Demand-paged address translator with a recency-ordered TLB
// A request item carries a 16-bit logical address (page in the high byte,
// offset in the low byte). The TLB is scanned one entry per cycle by a
// single tag comparator while the entries rotate through the shift line, so
// their recency order is restored when the scan ends. On a miss the page
// table (valid bits in flip-flops, frame map in a RAM) is consulted, and an
// absent page takes the next free frame. The pair then goes to the newest
// end of the TLB, evicting the oldest entry when the TLB is full.
// One response item follows each request: rsp_valid rises once the scan
// of the N occupied TLB entries (0 to TLB_DEPTH) and the resolve step are
// done. A new request item is taken only after the previous one has left
// the resolve step.
// req_stall is high from acceptance until the response is loaded, so the
// next item can be taken while a finished response still waits. When the
// receiver holds rsp_stall, a finished item waits in its last step.
// Reset (synchronous) empties the TLB, clears all page valid bits and the
// hit and fault totals, and restarts frame assignment at frame 0.
// ----------------------------------------------------------------------------
`include "tlb_page_table_translator_macros.svh"

module tlb_page_table_translator import tlbpt_pkg::*; #(
   parameter int TLB_DEPTH = TLB_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ADDR_W-1:0]    req_logical_address,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PAGE_W-1:0]    rsp_page_number,
   output logic [OFFSET_W-1:0]  rsp_page_offset,
   output logic [FRAME_W-1:0]   rsp_frame_number,
   output logic [ADDR_W-1:0]    rsp_physical_address,
   output logic                 rsp_tlb_hit,
   output logic                 rsp_page_fault,
   output logic [TOTAL_W-1:0]   rsp_hit_total,
   output logic [TOTAL_W-1:0]   rsp_fault_total
);

   localparam int CNT_W = $clog2(TLB_DEPTH + 1);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_SCAN    = 2'd1;
   localparam logic [1:0] ST_RESOLVE = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [CNT_W-1:0]        remain_ff, remain_in;
   logic                    hit_ff, hit_in;
   logic [FRAME_W-1:0]      hit_frame_ff, hit_frame_in;
   logic [PAGE_COUNT-1:0]   valid_bits_ff, valid_bits_in;
   logic [NEXT_FRAME_W-1:0] next_frame_ff, next_frame_in;
   logic [TOTAL_W-1:0]      hit_cnt_ff, hit_cnt_in;
   logic [TOTAL_W-1:0]      fault_cnt_ff, fault_cnt_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]      rsp_frame_ff, rsp_frame_in;
   logic [ADDR_W-1:0]       rsp_addr_ff, rsp_addr_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic                    rsp_fault_ff, rsp_fault_in;
   logic [TOTAL_W-1:0]      rsp_hit_total_ff, rsp_hit_total_in;
   logic [TOTAL_W-1:0]      rsp_fault_total_ff, rsp_fault_total_in;

   logic [PAGE_W-1:0]       page;
   logic                    req_accept;
   logic                    out_free;
   logic                    finish;
   logic                    page_valid;
   logic                    fault;
   logic [FRAME_W-1:0]      frame_sel;
   logic [FRAME_W-1:0]      map_rd_data;
   logic [PAGE_W-1:0]       map_rd_addr;
   tlb_cmd_type             tlb_cmd;
   tlb_entry_type           tlb_head;
   logic [CNT_W-1:0]        tlb_count;

   assign page       = addr_ff[ADDR_W-1:OFFSET_W];
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign finish     = (state_ff == ST_RESOLVE) && out_free;
   assign page_valid = valid_bits_ff[page];
   assign fault      = !hit_ff && !page_valid;
   assign frame_sel  = hit_ff ? hit_frame_ff :
                       (page_valid ? map_rd_data : next_frame_ff[FRAME_W-1:0]);
   assign map_rd_addr = req_accept ? req_logical_address[ADDR_W-1:OFFSET_W] : page;

   tlbpt_tlb #(
      .DEPTH (TLB_DEPTH),
      .CNT_W (CNT_W)
   ) u_tlb (
      .clock (clock),
      .reset (reset),
      .cmd   (tlb_cmd),
      .head  (tlb_head),
      .count (tlb_count)
   );

   tlbpt_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (PAGE_COUNT)
   ) u_frame_map (
      .clock   (clock),
      .wr_en   (finish && fault),
      .wr_addr (page),
      .wr_data (next_frame_ff[FRAME_W-1:0]),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   always_comb begin
      state_in           = state_ff;
      addr_in            = addr_ff;
      remain_in          = remain_ff;
      hit_in             = hit_ff;
      hit_frame_in       = hit_frame_ff;
      valid_bits_in      = valid_bits_ff;
      next_frame_in      = next_frame_ff;
      hit_cnt_in         = hit_cnt_ff;
      fault_cnt_in       = fault_cnt_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_frame_in       = rsp_frame_ff;
      rsp_addr_in        = rsp_addr_ff;
      rsp_hit_in         = rsp_hit_ff;
      rsp_fault_in       = rsp_fault_ff;
      rsp_hit_total_in   = rsp_hit_total_ff;
      rsp_fault_total_in = rsp_fault_total_ff;
      tlb_cmd.op         = TLB_HOLD;
      tlb_cmd.entry.tag  = page;
      tlb_cmd.entry.frame = frame_sel;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               addr_in   = req_logical_address;
               remain_in = tlb_count;
               hit_in    = 1'b0;
               state_in  = (tlb_count == '0) ? ST_RESOLVE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!hit_ff && tlb_head.tag == page) begin
               tlb_cmd.op   = TLB_DROP;
               hit_in       = 1'b1;
               hit_frame_in = tlb_head.frame;
            end else begin
               tlb_cmd.op = TLB_ROTATE;
            end
            remain_in = remain_ff - CNT_W'(1);
            if (remain_ff == CNT_W'(1)) begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            if (out_free) begin
               tlb_cmd.op = TLB_APPEND;
               if (hit_ff && hit_cnt_ff != TOTAL_MAX) begin
                  hit_cnt_in = hit_cnt_ff + TOTAL_W'(1);
               end
               if (fault) begin
                  valid_bits_in[page] = 1'b1;
                  if (next_frame_ff < NEXT_FRAME_W'(FRAME_COUNT)) begin
                     next_frame_in = next_frame_ff + NEXT_FRAME_W'(1);
                  end
                  if (fault_cnt_ff != TOTAL_MAX) begin
                     fault_cnt_in = fault_cnt_ff + TOTAL_W'(1);
                  end
               end
               rsp_valid_in       = 1'b1;
               rsp_frame_in       = frame_sel;
               rsp_addr_in        = addr_ff;
               rsp_hit_in         = hit_ff;
               rsp_fault_in       = fault;
               rsp_hit_total_in   = hit_cnt_in;
               rsp_fault_total_in = fault_cnt_in;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hit_ff        <= 1'b0;
         valid_bits_ff <= '0;
         next_frame_ff <= '0;
         hit_cnt_ff    <= '0;
         fault_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         remain_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         hit_ff        <= hit_in;
         valid_bits_ff <= valid_bits_in;
         next_frame_ff <= next_frame_in;
         hit_cnt_ff    <= hit_cnt_in;
         fault_cnt_ff  <= fault_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         remain_ff     <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff            <= addr_in;
      hit_frame_ff       <= hit_frame_in;
      rsp_frame_ff       <= rsp_frame_in;
      rsp_addr_ff        <= rsp_addr_in;
      rsp_hit_ff         <= rsp_hit_in;
      rsp_fault_ff       <= rsp_fault_in;
      rsp_hit_total_ff   <= rsp_hit_total_in;
      rsp_fault_total_ff <= rsp_fault_total_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_page_number      = rsp_addr_ff[ADDR_W-1:OFFSET_W];
   assign rsp_page_offset      = rsp_addr_ff[OFFSET_W-1:0];
   assign rsp_frame_number     = rsp_frame_ff;
   assign rsp_physical_address = {rsp_frame_ff, rsp_addr_ff[OFFSET_W-1:0]};
   assign rsp_tlb_hit          = rsp_hit_ff;
   assign rsp_page_fault       = rsp_fault_ff;
   assign rsp_hit_total        = rsp_hit_total_ff;
   assign rsp_fault_total      = rsp_fault_total_ff;

   `TLBPT_ASSERT_NEXT(a_accept_busy, clock, reset, req_accept, state_ff != ST_IDLE, "Accepted item did not start work")
   `TLBPT_ASSERT_IMPLY(a_scan_remain, clock, reset, state_ff == ST_SCAN, remain_ff != '0, "TLB scan running with nothing left")
   `TLBPT_ASSERT_IMPLY(a_hit_xor_fault, clock, reset, rsp_valid_ff, !(rsp_hit_ff && rsp_fault_ff), "Item reported both TLB hit and page fault")
   `TLBPT_ASSERT_ALWAYS(a_frame_bound, clock, reset, next_frame_ff <= NEXT_FRAME_W'(FRAME_COUNT), "Free frame pointer past frame count")

endmodule
